### hdl/mipbt_pkg.sv
// ----------------------------------------------------------------------------
// mipbt_pkg
// Shared types and constants for the masked ip block table.
// ----------------------------------------------------------------------------
package mipbt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;

  // opcodes
  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_RMGRP  = 3'd2;
  localparam logic [2:0] OP_LOOKUP = 3'd3;
  localparam logic [2:0] OP_TICK   = 3'd4;

  // result status codes
  localparam logic [2:0] ST_INSERTED    = 3'd0;
  localparam logic [2:0] ST_OVERWRITTEN = 3'd1;
  localparam logic [2:0] ST_REMOVED     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND   = 3'd3;
  localparam logic [2:0] ST_FULL        = 3'd4;
  localparam logic [2:0] ST_HIT         = 3'd5;
  localparam logic [2:0] ST_MISS        = 3'd6;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // capture request
    logic scan;      // examine entry at scan index
    logic scan_clr;  // restart scan index
    logic commit;    // perform insert write
    logic finish;    // build result
  } mipbt_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic scan_last;
  } mipbt_sts_t;

  // 0xFF in every non-wildcard octet
  function automatic logic [31:0] keep_mask(input logic [3:0] wild);
    logic [31:0] m;
    m = '0;
    for (int i = 0; i < 4; i++) begin
      if (!wild[i]) m[8*i +: 8] = 8'hFF;
    end
    return m;
  endfunction

endpackage

### hdl/mipbt_ctrl.sv
// ----------------------------------------------------------------------------
// mipbt_ctrl
// Request sequencer: accept, scan the table, commit, present result.
// ----------------------------------------------------------------------------
module mipbt_ctrl
  import mipbt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_fire,
  input  logic       out_busy,
  input  mipbt_sts_t sts,
  output logic       in_ready,
  output mipbt_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.load     = 1'b1;
          cmd.scan_clr = 1'b1;
          state_next   = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_busy) begin
          cmd.commit = 1'b1;
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### hdl/mipbt_dp.sv
// ----------------------------------------------------------------------------
// mipbt_dp
// Table storage, one-entry-per-cycle scan and result register.
// ----------------------------------------------------------------------------
module mipbt_dp
  import mipbt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  mipbt_cmd_t  cmd,
  output mipbt_sts_t  sts,
  input  logic [2:0]  opcode,
  input  logic [31:0] ip_address,
  input  logic [3:0]  octet_wildcard,
  input  logic [31:0] expiry_time,
  input  logic [7:0]  group_id,
  input  logic [31:0] now_time,
  input  logic        res_take,
  output logic        res_valid,
  output logic [2:0]  status,
  output logic [5:0]  entry_index,
  output logic [31:0] hit_end_time,
  output logic [7:0]  hit_group,
  output logic [6:0]  removed_count
);

  // table contents, valid bits in flops
  logic [TABLE_DEPTH-1:0] vld;
  logic [31:0] t_addr [TABLE_DEPTH];
  logic [3:0]  t_mask [TABLE_DEPTH];
  logic [31:0] t_end  [TABLE_DEPTH];
  logic [7:0]  t_grp  [TABLE_DEPTH];

  // captured request
  logic [2:0]  r_op;
  logic [31:0] r_ip, r_addr, r_exp, r_now;
  logic [3:0]  r_wild;
  logic [7:0]  r_grp;

  // scan state: sidx is the read address, pidx the entry being checked
  logic [IDX_W-1:0] sidx, pidx;
  logic             iss_done, p_act, rd_en, proc;
  logic             found, has_free, best_ok;
  logic [IDX_W-1:0] found_idx, free_idx, best_idx;
  logic [31:0]      best_addr, best_end;
  logic [7:0]       best_grp;
  logic [CNT_W-1:0] count;

  // current entry, read in the cycle before it is checked
  logic [31:0] e_addr, e_end, e_m;
  logic [3:0]  e_mask;
  logic [7:0]  e_grp;
  logic        e_vld, exact, kill;

  // insert target
  logic             ins_ok;
  logic [IDX_W-1:0] ins_idx;

  assign rd_en  = cmd.scan && !iss_done;
  assign proc   = cmd.scan && p_act;
  assign e_vld  = vld[pidx];
  assign e_m    = keep_mask(e_mask);
  assign exact  = e_vld && (e_addr == r_addr);
  assign sts.scan_last = p_act && (pidx == IDX_W'(TABLE_DEPTH - 1));

  // per-entry removal decision
  always_comb begin
    kill = 1'b0;
    case (r_op)
      OP_REMOVE: kill = exact;
      OP_RMGRP:  kill = e_vld && (e_grp == r_grp);
      OP_TICK:   kill = e_vld && (e_end != '0) && (e_end <= r_now);
      default:   kill = 1'b0;
    endcase
  end

  // request capture and scan
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_op   <= opcode;
      r_ip   <= ip_address;
      r_addr <= ip_address & keep_mask(octet_wildcard);
      r_wild <= octet_wildcard;
      r_exp  <= expiry_time;
      r_grp  <= group_id;
      r_now  <= now_time;
    end
    if (cmd.scan_clr) begin
      sidx     <= '0;
      iss_done <= 1'b0;
      p_act    <= 1'b0;
      found    <= 1'b0;
      has_free <= 1'b0;
      best_ok  <= 1'b0;
      count    <= '0;
    end else if (cmd.scan) begin
      p_act <= !iss_done;
      pidx  <= sidx;
      if (!iss_done) begin
        if (sidx == IDX_W'(TABLE_DEPTH - 1)) iss_done <= 1'b1;
        else                                 sidx     <= sidx + 1'b1;
      end
      if (p_act) begin
        if (exact && !found) begin
          found     <= 1'b1;
          found_idx <= pidx;
        end
        if (!e_vld && !has_free) begin
          has_free <= 1'b1;
          free_idx <= pidx;
        end
        if (e_vld && ((e_addr & e_m) == (r_ip & e_m))
            && (!best_ok || e_addr < best_addr)) begin
          best_ok   <= 1'b1;
          best_idx  <= pidx;
          best_addr <= e_addr;
          best_end  <= e_end;
          best_grp  <= e_grp;
        end
        if (kill && !(r_op == OP_REMOVE && found)) count <= count + 1'b1;
      end
    end
  end

  assign ins_ok  = found || has_free;
  assign ins_idx = found ? found_idx : free_idx;

  // table writes and registered entry read
  always_ff @(posedge clk) begin
    if (cmd.commit && r_op == OP_INSERT && ins_ok) begin
      t_addr[ins_idx] <= r_addr;
      t_mask[ins_idx] <= r_wild;
      t_end[ins_idx]  <= r_exp;
      t_grp[ins_idx]  <= r_grp;
    end
    if (rd_en) begin
      e_addr <= t_addr[sidx];
      e_mask <= t_mask[sidx];
      e_end  <= t_end[sidx];
      e_grp  <= t_grp[sidx];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (proc && kill && !(r_op == OP_REMOVE && found)) begin
      vld[pidx] <= 1'b0;
    end else if (cmd.commit && r_op == OP_INSERT && ins_ok) begin
      vld[ins_idx] <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.finish) begin
      res_valid     <= 1'b1;
      status        <= ST_NOT_FOUND;
      entry_index   <= '0;
      hit_end_time  <= '0;
      hit_group     <= '0;
      removed_count <= '0;
      case (r_op)
        OP_INSERT: begin
          status      <= found ? ST_OVERWRITTEN : (has_free ? ST_INSERTED : ST_FULL);
          entry_index <= ins_ok ? 6'(ins_idx) : '0;
        end
        OP_REMOVE: begin
          if (found) begin
            status      <= ST_REMOVED;
            entry_index <= 6'(found_idx);
          end
        end
        OP_RMGRP, OP_TICK: begin
          status        <= ST_REMOVED;
          removed_count <= (count > CNT_W'(127)) ? 7'd127 : 7'(count);
        end
        OP_LOOKUP: begin
          if (best_ok) begin
            status       <= ST_HIT;
            entry_index  <= 6'(best_idx);
            hit_end_time <= best_end;
            hit_group    <= best_grp;
          end else begin
            status <= ST_MISS;
          end
        end
        default: status <= ST_NOT_FOUND;
      endcase
    end else if (res_take) begin
      res_valid <= 1'b0;
    end
  end

endmodule

### hdl/masked_ip_block_table_top.sv
// ----------------------------------------------------------------------------
// masked_ip_block_table_top
// IPv4 block table with octet wildcards, groups and expiry.
// ----------------------------------------------------------------------------
// Each request is accepted in S_IDLE and scanned in S_SCAN, in which every table
// entry is read once and checked in the cycle after its read; S_DONE then commits
// the insert write and loads the result register. The sequencer holds in S_DONE
// while the result register still holds an untaken result; the next request is
// taken in the cycle after the result is loaded.
module masked_ip_block_table_top
  import mipbt_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // opcode[2:0], ip_address[34:3], octet_wildcard[38:35],
  // expiry_time[70:39], group_id[78:71], now_time[110:79], zero pad
  input  logic [111:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // status[2:0], entry_index[8:3], hit_end_time[40:9],
  // hit_group[48:41], removed_count[55:49]
  output logic [55:0]  m_tdata
);

  mipbt_cmd_t cmd;
  mipbt_sts_t sts;
  logic       rdy, res_valid;
  logic [2:0]  status;
  logic [5:0]  entry_index;
  logic [31:0] hit_end_time;
  logic [7:0]  hit_group;
  logic [6:0]  removed_count;

  assign s_tready = rdy;

  mipbt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (s_tvalid && rdy),
    .out_busy (res_valid && !m_tready),
    .sts      (sts),
    .in_ready (rdy),
    .cmd      (cmd)
  );

  mipbt_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .opcode         (s_tdata[2:0]),
    .ip_address     (s_tdata[34:3]),
    .octet_wildcard (s_tdata[38:35]),
    .expiry_time    (s_tdata[70:39]),
    .group_id       (s_tdata[78:71]),
    .now_time       (s_tdata[110:79]),
    .res_take       (m_tready),
    .res_valid      (res_valid),
    .status         (status),
    .entry_index    (entry_index),
    .hit_end_time   (hit_end_time),
    .hit_group      (hit_group),
    .removed_count  (removed_count)
  );

  assign m_tvalid = res_valid;
  assign m_tdata  = {removed_count, hit_group, hit_end_time, entry_index, status};

endmodule

### hdl/mipbt_checker.sv
// ----------------------------------------------------------------------------
// mipbt_checker
// Port-level checks for the block table.
// ----------------------------------------------------------------------------
module mipbt_checker
  import mipbt_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [55:0]  m_tdata
);

  // a request is never taken back to back
  a_no_b2b: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request taken in consecutive cycles");

  // no result appears right after acceptance
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !$rose(m_tvalid))
    else $error("result too early");

  // status code is in range
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:0] <= ST_MISS))
    else $error("bad status");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result changed while stalled");

endmodule

bind masked_ip_block_table_top mipbt_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stream-level check of the masked ip block table: a directed table of
// requests, a table fill and random traffic, checked against a table model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import mipbt_pkg::*;

  // first member lands in the highest bits, so the list runs from the top down
  typedef struct packed {
    logic [6:0]  count;
    logic [7:0]  grp;
    logic [31:0] hit_end;
    logic [5:0]  index;
    logic [2:0]  status;
  } verdict_t;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] ip;
    logic [3:0]  wild;
    logic [31:0] expiry;
    logic [7:0]  grp;
    logic [31:0] now;
    bit          fixed;
    verdict_t    want;
  } request_t;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [111:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [55:0]  m_tdata;

  // shadow table
  bit          tv [TABLE_DEPTH];
  logic [31:0] ta [TABLE_DEPTH];
  logic [3:0]  tw [TABLE_DEPTH];
  logic [31:0] te [TABLE_DEPTH];
  logic [7:0]  tg [TABLE_DEPTH];

  verdict_t pending_verdicts[$];
  int  errors = 0;
  bit  quiet = 0;
  bit  hold_sink = 0;
  int  n_sent = 0;
  int  sink_gap = 0;
  request_t directed[$];

  masked_ip_block_table_top dut (.*);

  always #4 clk = ~clk;

  function automatic logic [31:0] octet_keep(logic [3:0] w);
    logic [31:0] m;
    m = '0;
    for (int i = 0; i < 4; i++) if (!w[i]) m[8*i +: 8] = 8'hFF;
    return m;
  endfunction

  // apply one request to the shadow table and return the expected result
  function automatic verdict_t table_apply(request_t r);
    verdict_t v;
    logic [31:0] addr, m;
    int slot, cnt;
    v = '0;
    v.status = ST_NOT_FOUND;
    addr = r.ip & octet_keep(r.wild);
    slot = -1;
    cnt = 0;
    case (r.op)
      OP_INSERT: begin
        for (int i = 0; i < TABLE_DEPTH; i++)
          if (slot < 0 && tv[i] && ta[i] == addr) slot = i;
        if (slot >= 0) v.status = ST_OVERWRITTEN;
        else begin
          for (int i = 0; i < TABLE_DEPTH; i++) if (slot < 0 && !tv[i]) slot = i;
          v.status = (slot >= 0) ? ST_INSERTED : ST_FULL;
        end
        if (slot >= 0) begin
          tv[slot] = 1; ta[slot] = addr; tw[slot] = r.wild;
          te[slot] = r.expiry; tg[slot] = r.grp; v.index = 6'(slot);
        end
      end
      OP_REMOVE: begin
        for (int i = 0; i < TABLE_DEPTH; i++)
          if (slot < 0 && tv[i] && ta[i] == addr) slot = i;
        if (slot >= 0) begin
          tv[slot] = 0; v.status = ST_REMOVED; v.index = 6'(slot);
        end
      end
      OP_RMGRP, OP_TICK: begin
        for (int i = 0; i < TABLE_DEPTH; i++)
          if (tv[i] && ((r.op == OP_RMGRP) ? (tg[i] == r.grp)
                        : (te[i] != 0 && te[i] <= r.now))) begin
            tv[i] = 0; cnt++;
          end
        v.status = ST_REMOVED;
        v.count = (cnt > 127) ? 7'd127 : 7'(cnt);
      end
      OP_LOOKUP: begin
        for (int i = 0; i < TABLE_DEPTH; i++) if (tv[i]) begin
          m = octet_keep(tw[i]);
          if ((ta[i] & m) == (r.ip & m) && (slot < 0 || ta[i] < ta[slot])) slot = i;
        end
        if (slot >= 0) begin
          v.status = ST_HIT; v.index = 6'(slot); v.hit_end = te[slot]; v.grp = tg[slot];
        end else v.status = ST_MISS;
      end
      default: ;
    endcase
    return v;
  endfunction

  function automatic request_t mk(logic [2:0] op, logic [31:0] ip, logic [3:0] w,
                                  logic [31:0] e, logic [7:0] g, logic [31:0] n);
    request_t r;
    r.op = op; r.ip = ip; r.wild = w; r.expiry = e; r.grp = g; r.now = n;
    r.fixed = 0; r.want = '0;
    return r;
  endfunction

  function automatic request_t mk_fixed(request_t r, logic [2:0] st, logic [5:0] idx);
    r.fixed = 1; r.want = '0; r.want.status = st; r.want.index = idx;
    return r;
  endfunction

  task automatic add_row(request_t r);
    directed = {directed, r};
  endtask

  // random request drawn mostly from a small address pool so entries collide
  function automatic request_t rand_request();
    request_t r;
    int k;
    k = $urandom_range(0, 99);
    r = mk(3'($urandom_range(0, 4)), {8'd10, 8'($urandom_range(0, 3)),
           8'($urandom_range(0, 3)), 8'($urandom_range(0, 7))},
           4'($urandom_range(0, 15)), 32'($urandom_range(0, 40)),
           8'($urandom_range(0, 3)), 32'($urandom_range(0, 40)));
    if (k < 10) r.ip = $urandom;
    if (k < 5) r.op = 3'($urandom_range(0, 7));
    if (k >= 95) begin r.expiry = $urandom; r.now = $urandom; r.grp = 8'($urandom); end
    if ($urandom_range(0, 3) != 0) r.wild = r.wild & 4'b0001;
    if (r.op == OP_INSERT && $urandom_range(0, 3) == 0) r.expiry = '0;
    return r;
  endfunction

  task automatic send(request_t r);
    verdict_t v;
    v = table_apply(r);
    if (r.fixed && r.want != v) begin
      $error("directed row disagrees with model: table %h model %h", r.want, v);
      errors++;
    end
    if (r.fixed) v = r.want;
    pending_verdicts = {pending_verdicts, v};
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {1'b0, r.now, r.grp, r.expiry, r.wild, r.ip, r.op};
    // s_tready only moves at rising edges, so its level at the falling edge
    // tells whether the coming rising edge takes the transaction
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
    n_sent++;
  endtask

  // sink side with random idle bursts and one long hold
  always @(posedge clk) begin
    if (rst || hold_sink) m_tready <= 0;
    else if (quiet) m_tready <= 1;
    else if (sink_gap > 0) begin
      m_tready <= 0;
      sink_gap <= sink_gap - 1;
    end else if (m_tready && $urandom_range(0, 3) == 0) begin
      m_tready <= 0;
      sink_gap <= int'($urandom_range(0, 3));
    end else m_tready <= 1;
  end

  // result checker
  always @(posedge clk) begin
    verdict_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (pending_verdicts.size() == 0) begin
        $error("result with no request outstanding: %h", m_tdata);
        errors++;
      end else begin
        want = pending_verdicts.pop_front();
        if (got.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, got.status); errors++;
        end
        if (got.index !== want.index) begin
          $error("entry_index expected %0d actual %0d", want.index, got.index); errors++;
        end
        if (got.hit_end !== want.hit_end) begin
          $error("hit_end_time expected %0d actual %0d", want.hit_end, got.hit_end);
          errors++;
        end
        if (got.grp !== want.grp) begin
          $error("hit_group expected %0d actual %0d", want.grp, got.grp); errors++;
        end
        if (got.count !== want.count) begin
          $error("removed_count expected %0d actual %0d", want.count, got.count);
          errors++;
        end
      end
    end
  end

  // long sink hold-off, counted here
  initial begin
    wait (n_sent == 300);
    hold_sink = 1;
    repeat (600) @(posedge clk);
    hold_sink = 0;
  end

  initial begin
    #60ms;
    $display("FAIL");
    $finish;
  end

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) tv[i] = 0;
    repeat (3) @(posedge clk);
    rst <= 0;

    // directed rows
    add_row(mk_fixed(mk(OP_LOOKUP, 32'hFFFFFFFF, 4'h0, 32'h0, 8'h0, 32'h0), ST_MISS, 6'd0));
    add_row(mk_fixed(mk(OP_REMOVE, 32'h0, 4'h0, 32'h0, 8'h0, 32'h0), ST_NOT_FOUND, 6'd0));
    add_row(mk_fixed(mk(OP_INSERT, 32'hFFFFFFFF, 4'h0, 32'hFFFFFFFF, 8'hFF, 32'h0),
                     ST_INSERTED, 6'd0));
    add_row(mk_fixed(mk(OP_INSERT, 32'hFFFFFFFF, 4'h0, 32'd5, 8'd1, 32'h0),
                     ST_OVERWRITTEN, 6'd0));
    add_row(mk(OP_INSERT, 32'hC0A80123, 4'b0001, 32'h0, 8'h0, 32'h0));
    add_row(mk(OP_INSERT, 32'h0, 4'b1111, 32'd7, 8'd2, 32'h0));
    add_row(mk(OP_LOOKUP, 32'hC0A801FE, 4'b1111, 32'h0, 8'h0, 32'h0));
    add_row(mk(OP_LOOKUP, 32'h12345678, 4'h0, 32'h0, 8'h0, 32'h0));
    add_row(mk(OP_INSERT, 32'h0A0B0C0D, 4'b1010, 32'd3, 8'h0, 32'h0));
    add_row(mk(OP_TICK, 32'h0, 4'h0, 32'h0, 8'h0, 32'd4));
    add_row(mk(OP_TICK, 32'h0, 4'h0, 32'h0, 8'h0, 32'hFFFFFFFF));
    add_row(mk(OP_RMGRP, 32'h0, 4'h0, 32'h0, 8'h0, 32'h0));
    add_row(mk(OP_RMGRP, 32'h0, 4'h0, 32'h0, 8'hFF, 32'h0));
    add_row(mk_fixed(mk(3'd5, 32'hFFFFFFFF, 4'hF, 32'd1, 8'd1, 32'd1), ST_NOT_FOUND, 6'd0));
    add_row(mk_fixed(mk(3'd7, 32'h0, 4'h0, 32'h0, 8'h0, 32'h0), ST_NOT_FOUND, 6'd0));
    foreach (directed[i]) send(directed[i]);

    // fill the table to its limit, then one more
    for (int i = 0; i < TABLE_DEPTH + 1; i++)
      send(mk(OP_INSERT, 32'h20000000 + i, 4'h0, i, 8'd9, 32'h0));
    send(mk(OP_LOOKUP, 32'h20000000, 4'hF, 32'h0, 8'h0, 32'h0));
    send(mk(OP_RMGRP, 32'h0, 4'h0, 32'h0, 8'd9, 32'h0));

    // sender pause until every result is back
    s_tvalid <= 0;
    while (pending_verdicts.size() != 0) @(posedge clk);

    // random traffic, quiet tail at the end
    for (int i = 0; i < 1800; i++) begin
      if (i == 1600) quiet = 1;
      send(rand_request());
    end

    s_tvalid <= 0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

### sim.f
hdl/mipbt_pkg.sv
hdl/mipbt_ctrl.sv
hdl/mipbt_dp.sv
hdl/masked_ip_block_table_top.sv
hdl/mipbt_checker.sv
tb/tb.sv
